// ----- sv/looping_sample_player_defines.svh -----
// Assertion macros for the looping sample player; only the top file includes them.
// Depends on nothing; files that assert include it by name.
`ifndef LOOPING_SAMPLE_PLAYER_DEFINES_SVH
`define LOOPING_SAMPLE_PLAYER_DEFINES_SVH
`ifndef SYNTHESIS
`define LSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSP_ASSERT(lbl, prop, msg)
`define LSP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/lsp_pkg.sv -----
// Types and constants of the looping sample player.
// Used by the executor, mix stage, top and testbench; depends on nothing.
package lsp_pkg;

  localparam int FADE_J_W = 9;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_STOP  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_BAD_LSTART = 3'd2,
    ST_BAD_LEND   = 3'd3,
    ST_BEYOND     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_PLAY_MODE   = 3'd0,
    CFG_REVERSE     = 3'd1,
    CFG_START_POS   = 3'd2,
    CFG_END_POS     = 3'd3,
    CFG_LOOP_START  = 3'd4,
    CFG_LOOP_END    = 3'd5,
    CFG_SAMPLE_LEN  = 3'd6,
    CFG_GLIDE_TICKS = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_ONE_SHOT = 2'd0,
    MODE_FORWARD  = 2'd1,
    MODE_BACKWARD = 2'd2,
    MODE_PINGPONG = 2'd3
  } play_mode_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        load_addr;
    logic signed [15:0] load_data;
    logic [23:0]        start_step;
    logic signed [23:0] glide_step;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [16:0]        position;
    logic               playing;
    logic [2:0]         start_status;
  } out_item_t;

  typedef struct packed {
    logic                play;
    logic                fade;
    logic [FADE_J_W-1:0] fade_j;
    logic [16:0]         position;
    logic                playing;
    logic [2:0]          status;
  } mix_req_t;

endpackage

// ----- sv/lsp_ram.sv -----
// Generic single-port-write, registered-read RAM.
// Depends on nothing.
module lsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- sv/lsp_fifo.sv -----
// Small queue with push/full and pop/empty sides.
// Depends on nothing; used for the input and result queues.
module lsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= din;
    end
  end
endmodule

// ----- sv/lsp_exec.sv -----
// Executes one request per cycle while issue is high: registers, start checks, position and loop logic.
// Depends on lsp_pkg; drives the sample store and the mix stage.
module lsp_exec #(
  parameter int SAMPLE_DEPTH = 65536,
  parameter int FADE_LEN = 100
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [16:0]                     cfg_data,
  input  lsp_pkg::in_item_t               item,
  input  logic                            issue,
  output logic                            ram_we,
  output logic [$clog2(SAMPLE_DEPTH)-1:0] ram_waddr,
  output logic [15:0]                     ram_wdata,
  output logic                            ram_re,
  output logic [$clog2(SAMPLE_DEPTH)-1:0] ram_raddr,
  output lsp_pkg::mix_req_t               mreq
);
  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam logic [24:0] DEPTH_W = 25'(SAMPLE_DEPTH);
  localparam logic [34:0] FULL_MAX = {2'b0, {33{1'b1}}};

  logic [1:0]  play_mode;
  logic        reverse;
  logic [15:0] start_pos;
  logic [16:0] end_pos, loop_start, loop_end, sample_length;
  logic [15:0] glide_ticks;

  logic [16:0] pos_int, pos_int_next;
  logic [15:0] pos_frac, pos_frac_next;
  logic signed [24:0] step, step_next;
  logic active, active_next;
  logic backward_phase, backward_phase_next;
  logic [16:0] glide_count, glide_count_next;
  logic [15:0] glide_total, glide_total_next;
  logic signed [23:0] glide_inc, glide_inc_next;
  logic [lsp_pkg::FADE_J_W-1:0] fade_count, fade_count_next;
  logic [15:0] l_start, l_start_next;
  logic [16:0] l_end, l_end_next, l_lp1, l_lp1_next, l_lp2, l_lp2_next;
  logic [16:0] l_len, l_len_next;
  logic [1:0]  l_mode, l_mode_next;
  logic        l_rev, l_rev_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      play_mode     <= '0;
      reverse       <= 1'b0;
      start_pos     <= '0;
      end_pos       <= 17'h10000;
      loop_start    <= '0;
      loop_end      <= '0;
      sample_length <= '0;
      glide_ticks   <= '0;
    end else if (cfg_we) begin
      unique case (lsp_pkg::cfg_idx_t'(cfg_index))
        lsp_pkg::CFG_PLAY_MODE:   play_mode     <= cfg_data[1:0];
        lsp_pkg::CFG_REVERSE:     reverse       <= cfg_data[0];
        lsp_pkg::CFG_START_POS:   start_pos     <= cfg_data[15:0];
        lsp_pkg::CFG_END_POS:     end_pos       <= cfg_data;
        lsp_pkg::CFG_LOOP_START:  loop_start    <= cfg_data;
        lsp_pkg::CFG_LOOP_END:    loop_end      <= cfg_data;
        lsp_pkg::CFG_SAMPLE_LEN:  sample_length <= cfg_data;
        lsp_pkg::CFG_GLIDE_TICKS: glide_ticks   <= cfg_data[15:0];
      endcase
    end
  end

  always_comb begin
    logic        looped;
    logic [16:0] len, s17, a, b, pi;
    logic [15:0] pf;
    logic        bp, down;
    logic [2:0]  st;
    logic signed [25:0] gsum;
    logic signed [34:0] full, delta;

    pos_int_next        = pos_int;
    pos_frac_next       = pos_frac;
    step_next           = step;
    active_next         = active;
    backward_phase_next = backward_phase;
    glide_count_next    = glide_count;
    glide_total_next    = glide_total;
    glide_inc_next      = glide_inc;
    fade_count_next     = fade_count;
    l_start_next        = l_start;
    l_end_next          = l_end;
    l_lp1_next          = l_lp1;
    l_lp2_next          = l_lp2;
    l_len_next          = l_len;
    l_mode_next         = l_mode;
    l_rev_next          = l_rev;
    mreq                = '0;
    ram_we              = 1'b0;
    ram_waddr           = AW'(item.load_addr);
    ram_wdata           = item.load_data;
    ram_re              = 1'b0;
    ram_raddr           = AW'({1'b0, l_start} + {1'b0, pos_int});
    looped = play_mode != lsp_pkg::MODE_ONE_SHOT;
    len = ({8'b0, sample_length} > DEPTH_W) ? DEPTH_W[16:0] : sample_length;
    s17 = {1'b0, start_pos};
    a = looped ? loop_start : '0;
    b = looped ? loop_end : '0;
    st = lsp_pkg::ST_OK;
    pi = pos_int;
    pf = pos_frac;
    bp = backward_phase;
    down = 1'b0;
    gsum = '0;
    full = '0;
    delta = '0;

    unique case (lsp_pkg::req_type_t'(item.req_type))
      lsp_pkg::REQ_LOAD: begin
        ram_we = issue && ({9'b0, item.load_addr} < DEPTH_W);
      end
      lsp_pkg::REQ_START: begin
        if (active) begin
          fade_count_next = lsp_pkg::FADE_J_W'(FADE_LEN);
        end
        active_next         = 1'b0;
        backward_phase_next = 1'b0;
        pos_int_next        = '0;
        pos_frac_next       = '0;
        glide_count_next    = '0;
        priority if (s17 >= end_pos) begin
          st = lsp_pkg::ST_BAD_START;
        end else if (looped && (s17 > a || s17 > b)) begin
          st = lsp_pkg::ST_BAD_START;
        end else if (looped && (a > b || a > end_pos)) begin
          st = lsp_pkg::ST_BAD_LSTART;
        end else if (looped && b > end_pos) begin
          st = lsp_pkg::ST_BAD_LEND;
        end else if (s17 >= len || a > len || b > len || end_pos > len) begin
          st = lsp_pkg::ST_BEYOND;
        end else begin
          st = lsp_pkg::ST_OK;
        end
        if (st == lsp_pkg::ST_OK) begin
          l_start_next     = start_pos;
          l_end_next       = end_pos - s17;
          l_lp1_next       = looped ? a - s17 : '0;
          l_lp2_next       = looped ? b - s17 : '0;
          l_len_next       = len - s17;
          l_mode_next      = play_mode;
          l_rev_next       = reverse;
          step_next        = signed'({1'b0, item.start_step});
          glide_inc_next   = item.glide_step;
          glide_total_next = glide_ticks;
          pos_int_next     = reverse ? end_pos - s17 - 17'd1 : '0;
          active_next      = 1'b1;
        end
      end
      lsp_pkg::REQ_TICK: begin
        if (active && pos_int >= l_len) begin
          active_next = 1'b0;
        end else if (active) begin
          mreq.play = 1'b1;
          ram_re = issue;
          if (glide_total != '0 && glide_count <= {1'b0, glide_total}) begin
            gsum = 26'(step) + 26'(glide_inc);
            if (gsum > 26'sd16777215) begin
              step_next = 25'sd16777215;
            end else if (gsum < -26'sd16777216) begin
              step_next = -25'sd16777216;
            end else begin
              step_next = gsum[24:0];
            end
            glide_count_next = glide_count + 17'd1;
          end
          if (fade_count != '0) begin
            mreq.fade = 1'b1;
            mreq.fade_j = lsp_pkg::FADE_J_W'(FADE_LEN) - fade_count;
            fade_count_next = fade_count - 1'b1;
          end
          down = l_rev != backward_phase;
          delta = 35'(step_next);
          full = signed'({2'b0, pos_int, pos_frac}) + (down ? -delta : delta);
          if (full < 0) begin
            full = '0;
          end else if (full > signed'(FULL_MAX)) begin
            full = signed'(FULL_MAX);
          end
          pi = full[32:16];
          pf = full[15:0];
          if (l_mode == lsp_pkg::MODE_FORWARD) begin
            if (l_rev) begin
              if (pi <= l_lp1) begin
                pi = l_lp2;
                pf = '0;
              end
            end else if (pi >= l_lp2) begin
              pi = l_lp1;
              pf = '0;
            end
          end else if (l_mode != lsp_pkg::MODE_ONE_SHOT) begin
            if (l_rev) begin
              if (pi <= l_lp1 && !bp) begin
                pi = l_lp1;
                pf = '0;
                bp = 1'b1;
              end
              if (pi >= l_lp2 && bp) begin
                pf = '0;
                if (l_mode == lsp_pkg::MODE_PINGPONG) begin
                  pi = l_lp2;
                  bp = 1'b0;
                end else begin
                  pi = l_lp1;
                end
              end
            end else begin
              if (pi >= l_lp2 && !bp) begin
                pi = l_lp2;
                pf = '0;
                bp = 1'b1;
              end
              if (pi <= l_lp1 && bp) begin
                pf = '0;
                if (l_mode == lsp_pkg::MODE_PINGPONG) begin
                  pi = l_lp1;
                  bp = 1'b0;
                end else begin
                  pi = l_lp2;
                end
              end
            end
          end
          if (!l_rev && pi >= l_end && l_end != l_lp2) begin
            pi = l_len;
          end
          pos_int_next        = pi;
          pos_frac_next       = pf;
          backward_phase_next = bp;
        end
      end
      lsp_pkg::REQ_STOP: begin
        active_next = 1'b0;
      end
    endcase
    mreq.status   = st;
    mreq.position = pos_int_next;
    mreq.playing  = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_int        <= '0;
      pos_frac       <= '0;
      step           <= 25'sd65536;
      active         <= 1'b0;
      backward_phase <= 1'b0;
      glide_count    <= '0;
      glide_total    <= '0;
      glide_inc      <= '0;
      fade_count     <= '0;
      l_start        <= '0;
      l_end          <= '0;
      l_lp1          <= '0;
      l_lp2          <= '0;
      l_len          <= '0;
      l_mode         <= '0;
      l_rev          <= 1'b0;
    end else if (issue) begin
      pos_int        <= pos_int_next;
      pos_frac       <= pos_frac_next;
      step           <= step_next;
      active         <= active_next;
      backward_phase <= backward_phase_next;
      glide_count    <= glide_count_next;
      glide_total    <= glide_total_next;
      glide_inc      <= glide_inc_next;
      fade_count     <= fade_count_next;
      l_start        <= l_start_next;
      l_end          <= l_end_next;
      l_lp1          <= l_lp1_next;
      l_lp2          <= l_lp2_next;
      l_len          <= l_len_next;
      l_mode         <= l_mode_next;
      l_rev          <= l_rev_next;
    end
  end
endmodule

// ----- sv/lsp_mix.sv -----
// Output stage: takes the read sample, applies the crossfade and builds the result.
// Depends on lsp_pkg; fed by lsp_exec and the sample store.
module lsp_mix #(
  parameter int FADE_LEN = 100
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   issue,
  input  lsp_pkg::mix_req_t      mreq,
  input  logic [15:0]            rdata,
  input  logic                   out_full,
  output logic                   ready,
  output logic                   done,
  output lsp_pkg::out_item_t     result
);
  localparam longint unsigned DIV = longint'(FADE_LEN - 1);
  localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + DIV - 64'd1) / DIV);

  lsp_pkg::mix_req_t held;
  logic              busy;
  logic [1:0]        phase;
  logic signed [15:0] last_out;
  logic signed [25:0] num;
  logic               neg;
  logic [56:0]        prod;
  logic signed [15:0] smp;
  logic signed [25:0] p1, p2;
  logic [15:0]        q;

  assign done  = busy && (!held.fade || phase == 2'd2) && !out_full;
  assign ready = !busy || done;

  assign p1 = 26'(signed'(rdata)) * signed'({1'b0, 16'(held.fade_j)});
  assign p2 = 26'(last_out)
            * signed'({1'b0, 16'(lsp_pkg::FADE_J_W'(FADE_LEN - 1) - held.fade_j)});
  assign q  = prod[47:32];

  always_comb begin
    if (!held.play) begin
      smp = '0;
    end else if (held.fade) begin
      smp = neg ? -signed'(q) : signed'(q);
    end else begin
      smp = signed'(rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      phase    <= '0;
      last_out <= '0;
    end else begin
      if (issue) begin
        busy  <= 1'b1;
        phase <= '0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (busy && held.fade && phase != 2'd2) begin
        phase <= phase + 2'd1;
      end
      if (done && held.play) begin
        last_out <= smp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      held <= mreq;
    end
    if (busy && phase == 2'd0) begin
      num <= p1 + p2;
    end
    if (busy && phase == 2'd1) begin
      neg  <= num < 0;
      prod <= 57'(24'(num < 0 ? -num : num)) * 57'(RECIP);
    end
  end

  always_comb begin
    result.sample_out   = smp;
    result.position     = held.position;
    result.playing      = held.playing;
    result.start_status = held.status;
  end
endmodule

// ----- sv/looping_sample_player.sv -----
// Looping sample player: input queue, executor, sample store, mix stage, result queue.
// A result passes the store read and the mix stage's held request before it enters the result queue.
// Throughput: one item per cycle while the mix stage is ready; crossfade ticks hold it for its sum and product steps.
// The rate is set by the single execute stage and the one-read sample store.
// Reset (synchronous, rst high) clears the queues, registers and voice state.
// The sample store is not cleared and reads undefined until loaded.
`include "looping_sample_player_defines.svh"
module looping_sample_player #(
  parameter int SAMPLE_DEPTH = 65536,
  parameter int FADE_LEN = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lsp_pkg::in_item_t  req,
  output logic               full,
  input  logic               pop,
  output lsp_pkg::out_item_t rsp,
  output logic               empty,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  localparam int AW = $clog2(SAMPLE_DEPTH);

  lsp_pkg::in_item_t  in_item;
  lsp_pkg::mix_req_t  mreq;
  lsp_pkg::out_item_t mix_out;
  logic               in_empty, issue, mix_ready, mix_done, out_full;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [15:0]        ram_wdata, ram_rdata;

  assign issue = !in_empty && mix_ready;

  lsp_fifo #(.WIDTH($bits(lsp_pkg::in_item_t)), .DEPTH(2)) u_in_q (
    .clk(clk), .rst(rst), .push(push), .din(req), .full(full),
    .pop(issue), .dout(in_item), .empty(in_empty)
  );

  lsp_exec #(.SAMPLE_DEPTH(SAMPLE_DEPTH), .FADE_LEN(FADE_LEN)) u_exec (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item(in_item), .issue(issue), .ram_we(ram_we), .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata), .ram_re(ram_re), .ram_raddr(ram_raddr), .mreq(mreq)
  );

  lsp_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  lsp_mix #(.FADE_LEN(FADE_LEN)) u_mix (
    .clk(clk), .rst(rst), .issue(issue), .mreq(mreq), .rdata(ram_rdata),
    .out_full(out_full), .ready(mix_ready), .done(mix_done), .result(mix_out)
  );

  lsp_fifo #(.WIDTH($bits(lsp_pkg::out_item_t)), .DEPTH(2)) u_out_q (
    .clk(clk), .rst(rst), .push(mix_done), .din(mix_out), .full(out_full),
    .pop(pop), .dout(rsp), .empty(empty)
  );

  `LSP_ASSERT(a_no_out_overflow, mix_done |-> !out_full, "result queue overflow")
  `LSP_ASSERT(a_issue_has_item, issue |-> !in_empty, "issue from empty input queue")
  `LSP_ASSERT(a_store_one_access, !(ram_we && ram_re), "store written and read together")
  `LSP_ASSERT_ALWAYS(a_reset_empty, rst |=> (empty && !full), "queues not cleared by reset")
endmodule

// ----- test/tb_looping_sample_player.sv -----
// Testbench for looping_sample_player: loads, starts, ticks and stops with a predictor.
// Depends on lsp_pkg and the looping_sample_player RTL; needs no other file.
`timescale 1ns / 100ps

module tb_looping_sample_player;

  localparam int DEPTH = 65536;
  localparam int FADE = 100;
  localparam int WIN = 64;
  localparam int HI_BASE = DEPTH - WIN;
  localparam int LIMIT = 400000;
  localparam longint POS_MAX = (64'h1FFFF << 16) | 64'hFFFF;

  logic clk;
  logic rst;
  logic push;
  lsp_pkg::in_item_t req;
  logic full;
  logic pop;
  lsp_pkg::out_item_t rsp;
  logic empty;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [16:0] cfg_data;

  looping_sample_player dut (
    .clk(clk), .rst(rst), .push(push), .req(req), .full(full), .pop(pop), .rsp(rsp),
    .empty(empty), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lsp_pkg::in_item_t pending_items[$];
  lsp_pkg::out_item_t expected_rsp[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;

  // Voice predictor state.
  logic signed [15:0] sample_mem [DEPTH];
  bit loaded [DEPTH];
  int unsigned r_mode, r_rev, r_start, r_end, r_lp1, r_lp2, r_len, r_glide;
  int unsigned pos_int, pos_frac, glide_count, glide_total, fade_count;
  int step, glide_inc, last_out;
  bit active, back_phase, v_rev;
  int unsigned v_start, v_end, v_lp1, v_lp2, v_len, v_mode;

  function automatic int unsigned point_status();
    int unsigned len;
    len = r_len > DEPTH ? DEPTH : r_len;
    if (r_mode != lsp_pkg::MODE_ONE_SHOT) begin
      if (r_start >= r_end || r_start > r_lp1 || r_start > r_lp2)
        return lsp_pkg::ST_BAD_START;
      if (r_lp1 > r_lp2 || r_lp1 > r_end) return lsp_pkg::ST_BAD_LSTART;
      if (r_lp2 > r_end) return lsp_pkg::ST_BAD_LEND;
      if (r_lp1 > len || r_lp2 > len) return lsp_pkg::ST_BEYOND;
    end else if (r_start >= r_end) begin
      return lsp_pkg::ST_BAD_START;
    end
    if (r_start >= len || r_end > len) return lsp_pkg::ST_BEYOND;
    return lsp_pkg::ST_OK;
  endfunction

  function automatic int unsigned start_voice(int unsigned sstep, int ginc);
    int unsigned code;
    code = point_status();
    if (active) fade_count = FADE;
    active = 0;
    back_phase = 0;
    pos_int = 0;
    pos_frac = 0;
    glide_count = 0;
    if (code != lsp_pkg::ST_OK) return code;
    v_start = r_start;
    v_end = r_end - r_start;
    v_lp1 = r_mode != lsp_pkg::MODE_ONE_SHOT ? r_lp1 - r_start : 0;
    v_lp2 = r_mode != lsp_pkg::MODE_ONE_SHOT ? r_lp2 - r_start : 0;
    v_len = (r_len > DEPTH ? DEPTH : r_len) - r_start;
    v_mode = r_mode;
    v_rev = r_rev != 0;
    step = sstep;
    glide_inc = ginc;
    glide_total = r_glide;
    pos_int = v_rev ? v_end - 1 : 0;
    active = 1;
    return lsp_pkg::ST_OK;
  endfunction

  function automatic void jump_to(int unsigned p);
    pos_int = p;
    pos_frac = 0;
  endfunction

  function automatic void move_position();
    longint pos;
    bit down, pp;
    down = v_rev != back_phase;
    pos = (longint'(pos_int) << 16) | longint'(pos_frac);
    pos += down ? -longint'(step) : longint'(step);
    if (pos < 0) pos = 0;
    if (pos > POS_MAX) pos = POS_MAX;
    pos_int = int'(pos >> 16);
    pos_frac = int'(pos & 64'hFFFF);
    if (v_mode == lsp_pkg::MODE_FORWARD) begin
      if (v_rev) begin
        if (pos_int <= v_lp1) jump_to(v_lp2);
      end else if (pos_int >= v_lp2) begin
        jump_to(v_lp1);
      end
    end else if (v_mode == lsp_pkg::MODE_BACKWARD || v_mode == lsp_pkg::MODE_PINGPONG) begin
      pp = v_mode == lsp_pkg::MODE_PINGPONG;
      if (v_rev) begin
        if (pos_int <= v_lp1 && !back_phase) begin
          jump_to(v_lp1);
          back_phase = 1;
        end
        if (pos_int >= v_lp2 && back_phase) begin
          jump_to(pp ? v_lp2 : v_lp1);
          if (pp) back_phase = 0;
        end
      end else begin
        if (pos_int >= v_lp2 && !back_phase) begin
          jump_to(v_lp2);
          back_phase = 1;
        end
        if (pos_int <= v_lp1 && back_phase) begin
          jump_to(pp ? v_lp1 : v_lp2);
          if (pp) back_phase = 0;
        end
      end
    end
    if (!v_rev && pos_int >= v_end && v_end != v_lp2) pos_int = v_len;
  endfunction

  function automatic int play_tick();
    longint n;
    int s, o, j;
    if (!active) return 0;
    if (pos_int >= v_len) begin
      active = 0;
      return 0;
    end
    if (glide_total != 0 && glide_count <= glide_total) begin
      n = longint'(step) + glide_inc;
      if (n > 16777215) n = 16777215;
      if (n < -16777216) n = -16777216;
      step = int'(n);
      glide_count++;
    end
    s = sample_mem[v_start + pos_int];
    if (fade_count != 0) begin
      j = FADE - fade_count;
      o = (s * j + last_out * (FADE - 1 - j)) / (FADE - 1);
      fade_count--;
    end else begin
      o = s;
    end
    last_out = o;
    move_position();
    return o;
  endfunction

  function automatic lsp_pkg::out_item_t predict_voice(lsp_pkg::in_item_t it);
    lsp_pkg::out_item_t r;
    int smp;
    int unsigned code;
    smp = 0;
    code = lsp_pkg::ST_OK;
    case (it.req_type)
      lsp_pkg::REQ_LOAD: begin
        sample_mem[it.load_addr] = it.load_data;
        loaded[it.load_addr] = 1;
      end
      lsp_pkg::REQ_START: code = start_voice(it.start_step, int'(it.glide_step));
      lsp_pkg::REQ_TICK: smp = play_tick();
      default: active = 0;
    endcase
    r.sample_out = smp[15:0];
    r.position = pos_int[16:0];
    r.playing = active;
    r.start_status = code[2:0];
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic bit idle_now();
    return ((cycles % 25000) >= 4000) && ($urandom_range(0, 99) < 19);
  endfunction

  always @(negedge clk) begin
    if (!rst && pending_items.size() != 0 && !idle_now()) begin
      push <= 1'b1;
      req <= pending_items[0];
    end else begin
      push <= 1'b0;
    end
    pop <= !rst && !idle_now();
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_looping_sample_player NOT OK");
      $finish;
    end else if (!rst) begin
      if (push && !full) begin
        expected_rsp.push_back(predict_voice(req));
        void'(pending_items.pop_front());
        sent++;
      end
      if (pop && !empty) begin
        if (expected_rsp.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          lsp_pkg::out_item_t e;
          e = expected_rsp.pop_front();
          if (rsp.sample_out !== e.sample_out) begin
            $error("sample_out expected %0d got %0d", e.sample_out, rsp.sample_out);
            errors++;
          end
          if (rsp.position !== e.position) begin
            $error("position expected %0d got %0d", e.position, rsp.position);
            errors++;
          end
          if (rsp.playing !== e.playing) begin
            $error("playing expected %0d got %0d", e.playing, rsp.playing);
            errors++;
          end
          if (rsp.start_status !== e.start_status) begin
            $error("start_status expected %0d got %0d", e.start_status, rsp.start_status);
            errors++;
          end
        end
      end
    end
  end

  task automatic add_item(lsp_pkg::req_type_t kind, int unsigned addr, int data,
                          int unsigned sstep, int gstep);
    lsp_pkg::in_item_t it;
    it.req_type = kind;
    it.load_addr = addr[15:0];
    it.load_data = data[15:0];
    it.start_step = sstep[23:0];
    it.glide_step = gstep[23:0];
    pending_items.push_back(it);
  endtask

  task automatic add_noise(lsp_pkg::req_type_t kind);
    add_item(kind, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_rsp.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(lsp_pkg::cfg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[16:0];
    case (idx)
      lsp_pkg::CFG_PLAY_MODE: r_mode = val & 3;
      lsp_pkg::CFG_REVERSE: r_rev = val & 1;
      lsp_pkg::CFG_START_POS: r_start = val & 16'hFFFF;
      lsp_pkg::CFG_END_POS: r_end = val & 17'h1FFFF;
      lsp_pkg::CFG_LOOP_START: r_lp1 = val & 17'h1FFFF;
      lsp_pkg::CFG_LOOP_END: r_lp2 = val & 17'h1FFFF;
      lsp_pkg::CFG_SAMPLE_LEN: r_len = val & 17'h1FFFF;
      default: r_glide = val & 16'hFFFF;
    endcase
  endtask

  function automatic bit range_loaded();
    int unsigned len;
    len = r_len > DEPTH ? DEPTH : r_len;
    for (int unsigned a = r_start; a < len; a++) if (!loaded[a]) return 0;
    return 1;
  endfunction

  // Writes every register; a setting that would play unloaded samples gets length zero.
  task automatic configure(int unsigned m, int unsigned rv, int unsigned s, int unsigned e,
                           int unsigned a, int unsigned b, int unsigned len, int unsigned g);
    drain();
    write_reg(lsp_pkg::CFG_PLAY_MODE, m);
    write_reg(lsp_pkg::CFG_REVERSE, rv);
    write_reg(lsp_pkg::CFG_START_POS, s);
    write_reg(lsp_pkg::CFG_END_POS, e);
    write_reg(lsp_pkg::CFG_LOOP_START, a);
    write_reg(lsp_pkg::CFG_LOOP_END, b);
    write_reg(lsp_pkg::CFG_GLIDE_TICKS, g);
    write_reg(lsp_pkg::CFG_SAMPLE_LEN, len);
    if (point_status() == lsp_pkg::ST_OK && !range_loaded())
      write_reg(lsp_pkg::CFG_SAMPLE_LEN, 0);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic ticks(int n);
    repeat (n) add_item(lsp_pkg::REQ_TICK, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int unsigned base, len, s, e, a, b, g, sstep;
    int gstep;
    rst = 1;
    push = 0;
    pop = 0;
    req = '0;
    cfg_we = 0;
    cfg_index = lsp_pkg::CFG_PLAY_MODE;
    cfg_data = '0;
    r_mode = 0; r_rev = 0; r_start = 0; r_end = DEPTH; r_lp1 = 0; r_lp2 = 0;
    r_len = 0; r_glide = 0;
    pos_int = 0; pos_frac = 0; step = 65536; active = 0; back_phase = 0;
    glide_count = 0; glide_total = 0; glide_inc = 0; fade_count = 0; last_out = 0;
    v_start = 0; v_end = 0; v_lp1 = 0; v_lp2 = 0; v_len = 0; v_mode = 0; v_rev = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed part: idle tick and stop, store extremes, every status code, fades.
    ticks(1);
    add_noise(lsp_pkg::REQ_STOP);
    add_item(lsp_pkg::REQ_LOAD, 0, -32768, 0, 0);
    add_item(lsp_pkg::REQ_LOAD, DEPTH - 1, 32767, 0, 0);
    for (int i = 1; i < WIN; i++) add_item(lsp_pkg::REQ_LOAD, i, $urandom, 0, 0);
    for (int i = HI_BASE; i < DEPTH - 1; i++) add_item(lsp_pkg::REQ_LOAD, i, $urandom, 0, 0);
    configure(lsp_pkg::MODE_ONE_SHOT, 0, 0, 8, 0, 0, WIN, 0);
    add_item(lsp_pkg::REQ_START, 0, 0, 32'h10000, 0);
    ticks(10);
    configure(lsp_pkg::MODE_PINGPONG, 1, HI_BASE, DEPTH, HI_BASE + 4, DEPTH - 4, DEPTH, 3);
    add_item(lsp_pkg::REQ_START, 0, 0, 32'hFFFFFF, -8388608);
    ticks(3);
    add_item(lsp_pkg::REQ_START, 0, 0, 32'h18000, 8388607);
    ticks(5);
    add_noise(lsp_pkg::REQ_STOP);
    configure(lsp_pkg::MODE_FORWARD, 0, 9, 5, 9, 9, WIN, 0);
    add_item(lsp_pkg::REQ_START, 0, 0, 0, 0);
    configure(lsp_pkg::MODE_BACKWARD, 0, 2, 40, 30, 20, WIN, 0);
    add_item(lsp_pkg::REQ_START, 0, 0, 0, 0);
    configure(lsp_pkg::MODE_BACKWARD, 0, 2, 40, 10, 50, WIN, 0);
    add_item(lsp_pkg::REQ_START, 0, 0, 0, 0);
    configure(lsp_pkg::MODE_FORWARD, 0, 2, 100, 10, 20, WIN, 0);
    add_item(lsp_pkg::REQ_START, 0, 0, 0, 0);

    // Random phases of well-formed settings, with some broken ones.
    while (sent < 1800) begin
      base = $urandom_range(0, 1) ? HI_BASE : 0;
      len = base + $urandom_range(1, WIN);
      s = $urandom_range(base, len - 1);
      e = $urandom_range(s + 1, len);
      a = $urandom_range(s, e);
      b = $urandom_range(a, e);
      g = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 40);
      if ($urandom_range(0, 15) == 0) g = 16'hFFFF;
      case ($urandom_range(0, 9))
        0: e = $urandom_range(0, DEPTH);
        1: a = $urandom_range(0, DEPTH);
        2: b = $urandom_range(0, DEPTH);
        3: len = $urandom_range(0, 3) == 0 ? 17'h1FFFF : $urandom_range(0, DEPTH);
        4: s = $urandom_range(0, DEPTH - 1);
        default: ;
      endcase
      configure($urandom_range(0, 3), $urandom_range(0, 1), s, e, a, b, len, g);
      repeat ($urandom_range(1, 3)) begin
        sstep = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 32'h40000);
        gstep = $urandom_range(0, 7) == 0 ? int'($urandom) : $urandom_range(0, 2048) - 1024;
        add_item(lsp_pkg::REQ_START, 0, 0, sstep, gstep);
        repeat ($urandom_range(5, 60)) begin
          case ($urandom_range(0, 19))
            0: add_item(lsp_pkg::REQ_LOAD, $urandom_range(base, base + WIN - 1), $urandom,
                        $urandom, $urandom);
            1: add_item(lsp_pkg::REQ_LOAD, $urandom, $urandom, $urandom, $urandom);
            2: if ($urandom_range(0, 3) == 0) add_noise(lsp_pkg::REQ_STOP);
            default: ticks(1);
          endcase
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("tb_looping_sample_player OK");
    end else begin
      $display("tb_looping_sample_player NOT OK");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/lsp_pkg.sv
sv/lsp_ram.sv
sv/lsp_fifo.sv
sv/lsp_exec.sv
sv/lsp_mix.sv
sv/looping_sample_player.sv
test/tb_looping_sample_player.sv
